// ----- hdl/ringtone_note_parser_assert.svh -----
// ----------------------------------------------------------------------------
// ringtone note parser assertion macros
// shared helpers for the concurrent checks in the parser modules
// ----------------------------------------------------------------------------
`ifndef RINGTONE_NOTE_PARSER_ASSERT_SVH
`define RINGTONE_NOTE_PARSER_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define RTP_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ringtone note parser check failed");

// next-cycle implication, sampled on clock, off during reset
`define RTP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ringtone note parser check failed");

`endif

// ----- hdl/rtp_pkg.sv -----
// ----------------------------------------------------------------------------
// rtp_pkg
// shared widths, codes, pitch tables and word types of the note parser
// ----------------------------------------------------------------------------
package rtp_pkg;

   localparam int SYMBOL_W   = 8;
   localparam int COMPARE_W  = 15;
   localparam int LENGTH_W   = 7;
   localparam int DURATION_W = 6;
   localparam int OCTAVE_W   = 3;
   localparam int LETTER_W   = 4;

   // letter codes: 1..7 stand for a..g
   localparam logic [LETTER_W-1:0] LETTER_OTHER = 4'd0;
   localparam logic [LETTER_W-1:0] LETTER_PAUSE = 4'd8;

   localparam logic [COMPARE_W-1:0] START_COMPARE = 15'd18181;

   // zero marks a letter with no entry
   localparam logic [COMPARE_W-1:0] PLAIN_TABLE [8] = '{
      15'd0, 15'd18181, 15'd16197, 15'd15287, 15'd13618, 15'd12131, 15'd11449, 15'd10199
   };
   localparam logic [COMPARE_W-1:0] SHARP_TABLE [8] = '{
      15'd0, 15'd17159, 15'd0, 15'd14429, 15'd12852, 15'd0, 15'd10807, 15'd9627
   };

   // classified character as it travels from front to back
   typedef struct packed {
      logic [LETTER_W-1:0] letter;
      logic                is_one;
      logic                is_two;
      logic                is_three;
      logic                is_four;
      logic                is_six;
      logic                is_eight;
      logic                is_sharp;
      logic                is_dot;
      logic                is_comma;
      logic                is_octave;
      logic [OCTAVE_W-1:0] octave;
   } sym_class_type;

   typedef struct packed {
      logic [DURATION_W-1:0] default_duration;
      logic [OCTAVE_W-1:0]   default_octave;
   } cfg_type;

endpackage

// ----- hdl/ringtone_note_parser.sv -----
// ----------------------------------------------------------------------------
// ringtone_note_parser
// a result word is registered once its closing character leaves the queue
// throughput: one character per cycle unless stalled, set by the note sequencer
// the front stalls only while the queue is full behind a stalled result word
// reset: synchronous, clears parser state and loads register defaults
// ----------------------------------------------------------------------------
module ringtone_note_parser #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                          clock,
   input  logic                          reset,
   // character words in
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [rtp_pkg::SYMBOL_W-1:0]  req_symbol,
   // note result words out
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rtp_pkg::COMPARE_W-1:0] rsp_compare_value,
   output logic [rtp_pkg::LENGTH_W-1:0]  rsp_length_units,
   output logic                          rsp_silent,
   output logic                          rsp_last,
   // register writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [7:0]                    csr_wdata
);
   import rtp_pkg::*;

   // register indexes
   localparam logic [1:0] CSR_DEFAULT_DURATION = 2'd0;
   localparam logic [1:0] CSR_DEFAULT_OCTAVE   = 2'd1;

   // power-up defaults: quarter notes, octave 5
   localparam logic [DURATION_W-1:0] RESET_DURATION = 6'd4;
   localparam logic [OCTAVE_W-1:0]   RESET_OCTAVE   = 3'd5;

   cfg_type       cfg_ff, cfg_in;
   logic          queue_full;
   logic          push_valid;
   sym_class_type push_data;
   logic          pop_valid;
   logic          pop_ready;
   sym_class_type pop_data;

   // registers are always writable; the back end samples them live
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEFAULT_DURATION: cfg_in.default_duration = csr_wdata[DURATION_W-1:0];
            CSR_DEFAULT_OCTAVE:   cfg_in.default_octave   = csr_wdata[OCTAVE_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.default_duration <= RESET_DURATION;
         cfg_ff.default_octave   <= RESET_OCTAVE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: take a character word and classify it
   rtp_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_symbol (req_symbol),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   // decoupling queue so a stalled result does not block intake at once
   rtp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // back: grammar walk, one word per cycle unless stalled, registered result
   rtp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_data          (pop_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_compare_value (rsp_compare_value),
      .rsp_length_units  (rsp_length_units),
      .rsp_silent        (rsp_silent),
      .rsp_last          (rsp_last)
   );

endmodule

// ----- hdl/rtp_front.sv -----
// ----------------------------------------------------------------------------
// rtp_front
// accepts tune characters and classifies them for the back end
// ----------------------------------------------------------------------------
module rtp_front (
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [rtp_pkg::SYMBOL_W-1:0] req_symbol,
   input  logic                         queue_full,
   output logic                         push_valid,
   output rtp_pkg::sym_class_type       push_data
);
   import rtp_pkg::*;

   localparam logic [SYMBOL_W-1:0] CH_A     = 8'h61;
   localparam logic [SYMBOL_W-1:0] CH_G     = 8'h67;
   localparam logic [SYMBOL_W-1:0] CH_P     = 8'h70;
   localparam logic [SYMBOL_W-1:0] CH_1     = 8'h31;
   localparam logic [SYMBOL_W-1:0] CH_2     = 8'h32;
   localparam logic [SYMBOL_W-1:0] CH_3     = 8'h33;
   localparam logic [SYMBOL_W-1:0] CH_4     = 8'h34;
   localparam logic [SYMBOL_W-1:0] CH_6     = 8'h36;
   localparam logic [SYMBOL_W-1:0] CH_7     = 8'h37;
   localparam logic [SYMBOL_W-1:0] CH_8     = 8'h38;
   localparam logic [SYMBOL_W-1:0] CH_SHARP = 8'h23;
   localparam logic [SYMBOL_W-1:0] CH_DOT   = 8'h2e;
   localparam logic [SYMBOL_W-1:0] CH_COMMA = 8'h2c;

   assign req_stall  = queue_full;
   assign push_valid = req_valid && !queue_full;

   always_comb begin
      push_data = '0;
      if (req_symbol >= CH_A && req_symbol <= CH_G) begin
         push_data.letter = LETTER_W'(req_symbol - CH_A) + 4'd1;
      end else if (req_symbol == CH_P) begin
         push_data.letter = LETTER_PAUSE;
      end else begin
         push_data.letter = LETTER_OTHER;
      end
      push_data.is_one    = (req_symbol == CH_1);
      push_data.is_two    = (req_symbol == CH_2);
      push_data.is_three  = (req_symbol == CH_3);
      push_data.is_four   = (req_symbol == CH_4);
      push_data.is_six    = (req_symbol == CH_6);
      push_data.is_eight  = (req_symbol == CH_8);
      push_data.is_sharp  = (req_symbol == CH_SHARP);
      push_data.is_dot    = (req_symbol == CH_DOT);
      push_data.is_comma  = (req_symbol == CH_COMMA);
      push_data.is_octave = (req_symbol >= CH_4 && req_symbol <= CH_7);
      // '4'..'7' carry the octave in their low bits
      push_data.octave    = req_symbol[OCTAVE_W-1:0];
   end

endmodule

// ----- hdl/rtp_queue.sv -----
// ----------------------------------------------------------------------------
// rtp_queue
// short word queue between the classifying front and the parsing back
// ----------------------------------------------------------------------------
`include "ringtone_note_parser_assert.svh"

module rtp_queue #(
   parameter int DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  rtp_pkg::sym_class_type push_data,
   output logic                   full,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output rtp_pkg::sym_class_type pop_data
);
   import rtp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sym_class_type    slot_ff [DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = slot_ff[rptr_ff];
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push_valid) begin
         wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push_valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

   `RTP_ASSERT_SAME(a_no_overflow, push_valid, count_ff != CNT_W'(DEPTH))
   `RTP_ASSERT_NEXT(a_count_up, push_valid && !do_pop, count_ff == $past(count_ff) + 1'b1)
   `RTP_ASSERT_NEXT(a_count_hold, push_valid && do_pop, $stable(count_ff))

endmodule

// ----- hdl/rtp_back.sv -----
// ----------------------------------------------------------------------------
// rtp_back
// note grammar sequencer: updates the note state and registers each result
// ----------------------------------------------------------------------------
`include "ringtone_note_parser_assert.svh"

module rtp_back (
   input  logic                          clock,
   input  logic                          reset,
   input  rtp_pkg::cfg_type              cfg,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  rtp_pkg::sym_class_type        pop_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rtp_pkg::COMPARE_W-1:0] rsp_compare_value,
   output logic [rtp_pkg::LENGTH_W-1:0]  rsp_length_units,
   output logic                          rsp_silent,
   output logic                          rsp_last
);
   import rtp_pkg::*;

   typedef enum logic [8:0] {
      PH_DUR    = 9'b000000001,
      PH_DUR1   = 9'b000000010,
      PH_DUR3   = 9'b000000100,
      PH_LETTER = 9'b000001000,
      PH_AFTER  = 9'b000010000,
      PH_DOT1   = 9'b000100000,
      PH_OCT    = 9'b001000000,
      PH_DOT2   = 9'b010000000,
      PH_SEP    = 9'b100000000
   } phase_type;

   localparam logic [OCTAVE_W-1:0] RESET_OCTAVE = 3'd5;

   phase_type            phase_ff, phase_in;
   logic [LETTER_W-1:0]  letter_ff, letter_in;
   logic [LENGTH_W-1:0]  length_ff, length_in;
   logic [COMPARE_W-1:0] compare_ff, compare_in;
   logic [OCTAVE_W-1:0]  octave_ff, octave_in;
   logic                 pause_ff, pause_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COMPARE_W-1:0] rsp_compare_ff, rsp_compare_in;
   logic [LENGTH_W-1:0]  rsp_length_ff, rsp_length_in;
   logic                 rsp_silent_ff, rsp_silent_in;
   logic                 rsp_last_ff;

   logic                 fire;
   logic                 emit;

   // 32 / d with d = 0 read as 1
   function automatic logic [LENGTH_W-1:0] default_len(input logic [DURATION_W-1:0] d);
      logic [LENGTH_W-1:0] r;
      begin
         if (d <= 6'd1)       r = 7'd32;
         else if (d == 6'd2)  r = 7'd16;
         else if (d == 6'd3)  r = 7'd10;
         else if (d == 6'd4)  r = 7'd8;
         else if (d == 6'd5)  r = 7'd6;
         else if (d == 6'd6)  r = 7'd5;
         else if (d <= 6'd8)  r = 7'd4;
         else if (d <= 6'd10) r = 7'd3;
         else if (d <= 6'd16) r = 7'd2;
         else if (d <= 6'd32) r = 7'd1;
         else                 r = 7'd0;
         default_len = r;
      end
   endfunction

   // one dot: times 1.5, rounded down
   function automatic logic [LENGTH_W-1:0] dotted(input logic [LENGTH_W-1:0] len);
      begin
         dotted = len + {1'b0, len[LENGTH_W-1:1]};
      end
   endfunction

   assign pop_ready = !rsp_valid_ff || !rsp_stall;
   assign fire      = pop_valid && pop_ready;

   always_comb begin
      logic go_after;
      logic go_dot1;
      logic go_oct;
      logic go_dot2;
      logic go_sep;
      logic [COMPARE_W-1:0] entry;
      logic [COMPARE_W-1:0] shifted;

      go_after = 1'b0;
      go_dot1  = 1'b0;
      go_oct   = 1'b0;
      go_dot2  = 1'b0;
      go_sep   = 1'b0;
      entry    = '0;
      shifted  = '0;
      emit     = 1'b0;

      rsp_length_in = '0;
      rsp_silent_in = 1'b0;

      phase_in   = phase_ff;
      letter_in  = letter_ff;
      length_in  = length_ff;
      compare_in = compare_ff;
      octave_in  = octave_ff;
      pause_in   = pause_ff;

      case (phase_ff)
         PH_DUR: begin
            octave_in = cfg.default_octave;
            pause_in  = 1'b0;
            if (pop_data.is_three) begin
               phase_in = PH_DUR3;
            end else if (pop_data.is_one) begin
               phase_in = PH_DUR1;
            end else if (pop_data.is_two) begin
               length_in = 7'd16;
               phase_in  = PH_LETTER;
            end else if (pop_data.is_four) begin
               length_in = 7'd8;
               phase_in  = PH_LETTER;
            end else if (pop_data.is_eight) begin
               length_in = 7'd4;
               phase_in  = PH_LETTER;
            end else begin
               length_in = default_len(cfg.default_duration);
               letter_in = pop_data.letter;
               phase_in  = PH_AFTER;
            end
         end
         PH_DUR3: begin
            if (pop_data.is_two) begin
               length_in = 7'd1;
               phase_in  = PH_LETTER;
            end else begin
               // lone '3' is the letter slot itself
               length_in = default_len(cfg.default_duration);
               letter_in = LETTER_OTHER;
               go_after  = 1'b1;
            end
         end
         PH_DUR1: begin
            if (pop_data.is_six) begin
               length_in = 7'd2;
               phase_in  = PH_LETTER;
            end else begin
               length_in = 7'd32;
               letter_in = pop_data.letter;
               phase_in  = PH_AFTER;
            end
         end
         PH_LETTER: begin
            letter_in = pop_data.letter;
            phase_in  = PH_AFTER;
         end
         PH_AFTER: go_after = 1'b1;
         PH_DOT1:  go_dot1  = 1'b1;
         PH_OCT:   go_oct   = 1'b1;
         PH_DOT2:  go_dot2  = 1'b1;
         PH_SEP:   go_sep   = 1'b1;
         default:  phase_in = PH_DUR;
      endcase

      if (go_after) begin
         if (pop_data.is_sharp) begin
            if (!letter_in[LETTER_W-1]) begin
               entry = SHARP_TABLE[letter_in[2:0]];
            end
            if (entry != '0) begin
               compare_in = entry;
            end
            phase_in = PH_DOT1;
         end else begin
            if (letter_in == LETTER_PAUSE) begin
               pause_in = 1'b1;
            end else begin
               if (!letter_in[LETTER_W-1]) begin
                  entry = PLAIN_TABLE[letter_in[2:0]];
               end
               if (entry != '0) begin
                  compare_in = entry;
               end
            end
            go_dot1 = 1'b1;
         end
      end

      if (go_dot1) begin
         phase_in = PH_OCT;
         if (pop_data.is_dot) begin
            length_in = dotted(length_in);
         end else begin
            go_oct = 1'b1;
         end
      end

      if (go_oct) begin
         phase_in = PH_DOT2;
         if (pop_data.is_octave) begin
            octave_in = pop_data.octave;
         end else begin
            go_dot2 = 1'b1;
         end
      end

      if (go_dot2) begin
         phase_in = PH_SEP;
         if (pop_data.is_dot) begin
            length_in = dotted(length_in);
         end else begin
            go_sep = 1'b1;
         end
      end

      if (go_sep) begin
         emit = 1'b1;
         // note length and pause as they stand before the note state clears
         rsp_length_in = length_in;
         rsp_silent_in = pause_in;
         case (octave_in)
            3'd5:    shifted = compare_in >> 1;
            3'd6:    shifted = compare_in >> 2;
            3'd7:    shifted = compare_in >> 3;
            default: shifted = compare_in;
         endcase
         phase_in  = PH_DUR;
         letter_in = LETTER_OTHER;
         pause_in  = 1'b0;
         if (pop_data.is_comma) begin
            compare_in = shifted;
         end else begin
            // tune over: back to the power-up note state
            compare_in = START_COMPARE;
            length_in  = '0;
            octave_in  = RESET_OCTAVE;
         end
      end

      rsp_compare_in = shifted;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = emit;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_DUR;
         letter_ff    <= LETTER_OTHER;
         length_ff    <= '0;
         compare_ff   <= START_COMPARE;
         octave_ff    <= RESET_OCTAVE;
         pause_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            phase_ff   <= phase_in;
            letter_ff  <= letter_in;
            length_ff  <= length_in;
            compare_ff <= compare_in;
            octave_ff  <= octave_in;
            pause_ff   <= pause_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && emit) begin
         rsp_compare_ff <= rsp_compare_in;
         rsp_length_ff  <= rsp_length_in;
         rsp_silent_ff  <= rsp_silent_in;
         rsp_last_ff    <= !pop_data.is_comma;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_compare_value = rsp_compare_ff;
   assign rsp_length_units  = rsp_length_ff;
   assign rsp_silent        = rsp_silent_ff;
   assign rsp_last          = rsp_last_ff;

   `RTP_ASSERT_SAME(a_emit_after_letter, fire && emit, !(phase_ff == PH_DUR || phase_ff == PH_DUR1 || phase_ff == PH_LETTER))
   `RTP_ASSERT_NEXT(a_note_restarts, fire && emit, phase_ff == PH_DUR && letter_ff == LETTER_OTHER && !pause_ff)
   `RTP_ASSERT_NEXT(a_tune_end_reload, fire && emit && !pop_data.is_comma, compare_ff == START_COMPARE && length_ff == '0)

endmodule

// ----- tb/sv/tb_ringtone_note_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ringtone_note_parser
// feeds tune text one character word at a time and checks every note word
// against an in-bench parser model, across several default register settings
// ----------------------------------------------------------------------------
module tb_ringtone_note_parser;

   import rtp_pkg::*;

   // register indexes of the csr channel
   localparam logic [1:0] REG_DEFAULT_DURATION = 2'd0;
   localparam logic [1:0] REG_DEFAULT_OCTAVE   = 2'd1;

   // characters with a meaning in the tune text
   localparam logic [7:0] CH_ZERO  = "0";
   localparam logic [7:0] CH_ONE   = "1";
   localparam logic [7:0] CH_TWO   = "2";
   localparam logic [7:0] CH_THREE = "3";
   localparam logic [7:0] CH_FOUR  = "4";
   localparam logic [7:0] CH_SIX   = "6";
   localparam logic [7:0] CH_SEVEN = "7";
   localparam logic [7:0] CH_EIGHT = "8";
   localparam logic [7:0] CH_SHARP = "#";
   localparam logic [7:0] CH_DOT   = ".";
   localparam logic [7:0] CH_COMMA = ",";
   localparam logic [7:0] CH_END   = ";";
   localparam logic [7:0] CH_LOW_A = "a";
   localparam logic [7:0] CH_LOW_G = "g";
   localparam logic [7:0] CH_LOW_P = "p";

   // pending duration digit
   localparam logic [1:0] DIGIT_NONE  = 2'd0;
   localparam logic [1:0] DIGIT_ONE   = 2'd1;
   localparam logic [1:0] DIGIT_THREE = 2'd3;

   localparam int PHASE_ITEMS    = 195;   // random characters per register setting
   localparam int SETTLE_CYCLES  = 10;    // idle settling time after each drain
   localparam int WATCHDOG_LIMIT = 1000;  // cycles with no handshake at all
   localparam int HOLD_AT        = 300;   // characters taken before the long result hold-off
   localparam int HOLD_CYCLES    = 60;
   localparam int CALM_FROM      = 700;   // window of characters with no idling on either side
   localparam int CALM_TO        = 900;

   typedef enum logic [2:0] {
      AT_DURATION, AT_LETTER, AT_SHARP, AT_FIRST_DOT, AT_OCTAVE, AT_SECOND_DOT, AT_SEPARATOR
   } parse_step_type;

   typedef struct packed {
      logic [COMPARE_W-1:0] compare_value;
      logic [LENGTH_W-1:0]  length_units;
      logic                 silent;
      logic                 last;
   } note_word_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [SYMBOL_W-1:0]  req_symbol = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [COMPARE_W-1:0] rsp_compare_value;
   logic [LENGTH_W-1:0]  rsp_length_units;
   logic                 rsp_silent;
   logic                 rsp_last;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [1:0]           csr_index = '0;
   logic [7:0]           csr_wdata = '0;

   logic [SYMBOL_W-1:0] symbol_queue [$];    // characters waiting to be offered
   note_word_type       expected_notes [$];  // note words predicted, oldest first
   int                  chars_taken = 0;
   int                  fail_count = 0;
   int                  quiet_cycles = 0;
   wire                 calm_stretch = (chars_taken >= CALM_FROM) && (chars_taken < CALM_TO);

   // parser model state and its copy of the registers
   logic [DURATION_W-1:0] cfg_duration;
   logic [OCTAVE_W-1:0]   cfg_octave;
   parse_step_type        step_now;
   logic [1:0]            digit_now;
   logic [LETTER_W-1:0]   letter_now;
   logic [LENGTH_W-1:0]   length_now;
   logic [COMPARE_W-1:0]  pitch_now;
   logic [OCTAVE_W-1:0]   octave_now;
   logic                  pause_now;

   always #5 clock = ~clock;

   ringtone_note_parser u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_symbol        (req_symbol),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_compare_value (rsp_compare_value),
      .rsp_length_units  (rsp_length_units),
      .rsp_silent        (rsp_silent),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // ---------------------------------------------------------------------------
   // parser model
   // ---------------------------------------------------------------------------

   // a..g map to 1..7, p is a pause, anything else keeps the held pitch
   function automatic logic [LETTER_W-1:0] letter_of(input logic [7:0] c);
      if (c >= CH_LOW_A && c <= CH_LOW_G)
         return LETTER_W'(c - CH_LOW_A + 1);
      if (c == CH_LOW_P)
         return LETTER_PAUSE;
      return LETTER_OTHER;
   endfunction

   // timer compare value per letter, zero where the letter has no entry
   function automatic logic [COMPARE_W-1:0] pitch_of(input logic [LETTER_W-1:0] letter,
                                                     input logic sharp);
      if (sharp) begin
         case (letter)
            4'd1:    return 15'd17159;
            4'd3:    return 15'd14429;
            4'd4:    return 15'd12852;
            4'd6:    return 15'd10807;
            4'd7:    return 15'd9627;
            default: return 15'd0;
         endcase
      end
      case (letter)
         4'd1:    return 15'd18181;
         4'd2:    return 15'd16197;
         4'd3:    return 15'd15287;
         4'd4:    return 15'd13618;
         4'd5:    return 15'd12131;
         4'd6:    return 15'd11449;
         4'd7:    return 15'd10199;
         default: return 15'd0;
      endcase
   endfunction

   // zero counts as one; anything above 32 truncates to zero length
   function automatic logic [LENGTH_W-1:0] default_units();
      logic [DURATION_W-1:0] d;
      d = (cfg_duration == '0) ? DURATION_W'(1) : cfg_duration;
      return LENGTH_W'(32 / d);
   endfunction

   function automatic logic [LENGTH_W-1:0] dotted(input logic [LENGTH_W-1:0] units);
      return LENGTH_W'(units + (units >> 1));
   endfunction

   function automatic void clear_parser();
      step_now   = AT_DURATION;
      digit_now  = DIGIT_NONE;
      letter_now = LETTER_OTHER;
      length_now = '0;
      pitch_now  = START_COMPARE;
      octave_now = 3'd5;
      pause_now  = 1'b0;
   endfunction

   // advances the model by one character, queuing a note word when one closes;
   // some characters fall through several optional slots before they are used
   function automatic void parse_symbol(input logic [7:0] c);
      logic          used;
      note_word_type note;
      used = 1'b0;
      while (!used) begin
         used = 1'b1;
         case (step_now)
            AT_DURATION: begin
               if (digit_now == DIGIT_NONE) begin
                  octave_now = cfg_octave;
                  pause_now  = 1'b0;
                  if (c == CH_THREE) begin
                     digit_now = DIGIT_THREE;
                  end else if (c == CH_ONE) begin
                     digit_now = DIGIT_ONE;
                  end else if (c == CH_EIGHT || c == CH_FOUR || c == CH_TWO) begin
                     length_now = LENGTH_W'(32 / (c - CH_ZERO));
                     step_now   = AT_LETTER;
                  end else begin
                     length_now = default_units();
                     letter_now = letter_of(c);
                     step_now   = AT_SHARP;
                  end
               end else if (digit_now == DIGIT_THREE) begin
                  // a lone 3 is the letter itself, so this character moves on
                  digit_now = DIGIT_NONE;
                  if (c == CH_TWO) begin
                     length_now = 7'd1;
                     step_now   = AT_LETTER;
                  end else begin
                     length_now = default_units();
                     letter_now = LETTER_OTHER;
                     step_now   = AT_SHARP;
                     used       = 1'b0;
                  end
               end else begin
                  // a 1 not followed by 6 is a whole note and this is its letter
                  digit_now = DIGIT_NONE;
                  if (c == CH_SIX) begin
                     length_now = 7'd2;
                     step_now   = AT_LETTER;
                  end else begin
                     length_now = 7'd32;
                     letter_now = letter_of(c);
                     step_now   = AT_SHARP;
                  end
               end
            end
            AT_LETTER: begin
               letter_now = letter_of(c);
               step_now   = AT_SHARP;
            end
            AT_SHARP: begin
               step_now = AT_FIRST_DOT;
               if (c == CH_SHARP) begin
                  // p# is neither a pause nor a pitch
                  if (pitch_of(letter_now, 1'b1) != '0)
                     pitch_now = pitch_of(letter_now, 1'b1);
               end else begin
                  if (letter_now == LETTER_PAUSE)
                     pause_now = 1'b1;
                  else if (pitch_of(letter_now, 1'b0) != '0)
                     pitch_now = pitch_of(letter_now, 1'b0);
                  used = 1'b0;
               end
            end
            AT_FIRST_DOT: begin
               step_now = AT_OCTAVE;
               if (c == CH_DOT)
                  length_now = dotted(length_now);
               else
                  used = 1'b0;
            end
            AT_OCTAVE: begin
               step_now = AT_SECOND_DOT;
               if (c >= CH_FOUR && c <= CH_SEVEN)
                  octave_now = OCTAVE_W'(c - CH_ZERO);
               else
                  used = 1'b0;
            end
            AT_SECOND_DOT: begin
               step_now = AT_SEPARATOR;
               if (c == CH_DOT)
                  length_now = dotted(length_now);
               else
                  used = 1'b0;
            end
            default: begin
               // octave shift lands in the held pitch, pauses included
               case (octave_now)
                  3'd5:    pitch_now = pitch_now >> 1;
                  3'd6:    pitch_now = pitch_now >> 2;
                  3'd7:    pitch_now = pitch_now >> 3;
                  default: pitch_now = pitch_now;
               endcase
               note.compare_value = pitch_now;
               note.length_units  = length_now;
               note.silent        = pause_now;
               note.last          = (c != CH_COMMA);
               expected_notes.push_back(note);
               if (note.last) begin
                  clear_parser();
               end else begin
                  step_now   = AT_DURATION;
                  digit_now  = DIGIT_NONE;
                  letter_now = LETTER_OTHER;
                  pause_now  = 1'b0;
               end
            end
         endcase
      end
   endfunction

   // ---------------------------------------------------------------------------
   // character driver: idles at random, holds a stalled word steady
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            parse_symbol(req_symbol);
            chars_taken <= chars_taken + 1;
         end
         if (!req_valid || !req_stall) begin
            if (symbol_queue.size() > 0 && (calm_stretch || $urandom_range(99) >= 36)) begin
               req_valid  <= 1'b1;
               req_symbol <= symbol_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // note monitor: random stall plus one long hold-off that backs up the input
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : note_monitor
      note_word_type want;
      int            hold_left;
      bit            hold_done;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
         hold_done = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_notes.size() == 0) begin
               $error("unexpected note word: compare_value %0d length_units %0d",
                      rsp_compare_value, rsp_length_units);
               fail_count++;
            end else begin
               want = expected_notes.pop_front();
               if (rsp_compare_value !== want.compare_value) begin
                  $error("compare_value: expected %0d, got %0d",
                         want.compare_value, rsp_compare_value);
                  fail_count++;
               end
               if (rsp_length_units !== want.length_units) begin
                  $error("length_units: expected %0d, got %0d",
                         want.length_units, rsp_length_units);
                  fail_count++;
               end
               if (rsp_silent !== want.silent) begin
                  $error("silent: expected %0d, got %0d", want.silent, rsp_silent);
                  fail_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_last);
                  fail_count++;
               end
            end
         end
         if (!hold_done && chars_taken >= HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm_stretch && ($urandom_range(99) < 36);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // watchdog: no handshake on any channel for too long ends the run
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL ringtone_note_parser");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------

   // all characters taken and every note word back; polled away from the edge
   task automatic wait_until_drained();
      do
         @(negedge clock);
      while (symbol_queue.size() > 0 || req_valid || expected_notes.size() > 0);
   endtask

   // upper data bits are junk on purpose, the register keeps only its width
   task automatic write_register(input logic [1:0] index, input logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      case (index)
         REG_DEFAULT_DURATION: cfg_duration = value[DURATION_W-1:0];
         REG_DEFAULT_OCTAVE:   cfg_octave   = value[OCTAVE_W-1:0];
         default:              ;
      endcase
      csr_valid <= 1'b0;
   endtask

   initial begin
      string                 directed;
      string                 letters;
      logic [DURATION_W-1:0] duration_set [6];
      logic [OCTAVE_W-1:0]   octave_set [6];
      logic [DURATION_W-1:0] dur;
      logic [OCTAVE_W-1:0]   oct;
      int                    k;

      // extremes, then zero and oversize durations and octaves outside 4..7
      duration_set = '{6'd1, 6'd32, 6'd0, 6'd40, 6'd8, 6'd63};
      octave_set   = '{3'd4, 3'd7, 3'd6, 3'd2, 3'd5, 3'd0};
      letters      = "abcdefgp";

      cfg_duration = 6'd4;
      cfg_octave   = 3'd5;
      clear_parser();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed text at reset defaults: every duration form, sharps that hit
      // and miss, sharp pause, dots on both sides of the octave, lone 1 and
      // lone 3, and the extreme character codes as letter and separator
      directed = "32a#.7.,1p#4,16p.,8e#6,4b#,3";
      for (int i = 0; i < directed.len(); i++)
         symbol_queue.push_back(directed[i]);
      symbol_queue.push_back(8'hFF);
      symbol_queue.push_back(CH_TWO);
      symbol_queue.push_back(8'h00);
      directed = ".4.;";
      for (int i = 0; i < directed.len(); i++)
         symbol_queue.push_back(directed[i]);
      wait_until_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);

      for (int phase = 0; phase < 8; phase++) begin
         if (phase < 6) begin
            dur = duration_set[phase];
            oct = octave_set[phase];
         end else begin
            dur = DURATION_W'($urandom_range(1, 32));
            oct = OCTAVE_W'($urandom_range(4, 7));
         end
         write_register(REG_DEFAULT_DURATION, {2'($urandom_range(3)), dur});
         write_register(REG_DEFAULT_OCTAVE, {5'($urandom_range(31)), oct});

         // mostly well-formed notes with random parts, some raw noise
         while (symbol_queue.size() < PHASE_ITEMS) begin
            if ($urandom_range(99) < 8) begin
               symbol_queue.push_back(8'($urandom_range(255)));
            end else begin
               case ($urandom_range(8))
                  0: symbol_queue.push_back(CH_ONE);
                  1: symbol_queue.push_back(CH_TWO);
                  2: symbol_queue.push_back(CH_FOUR);
                  3: symbol_queue.push_back(CH_EIGHT);
                  4: begin
                     symbol_queue.push_back(CH_ONE);
                     symbol_queue.push_back(CH_SIX);
                  end
                  5: begin
                     symbol_queue.push_back(CH_THREE);
                     symbol_queue.push_back(CH_TWO);
                  end
                  6: symbol_queue.push_back(CH_THREE);
                  default: ;
               endcase
               k = $urandom_range(19);
               if (k < 16)
                  symbol_queue.push_back(letters[k % 8]);
               else
                  symbol_queue.push_back(8'($urandom_range(255)));
               if ($urandom_range(2) == 0)
                  symbol_queue.push_back(CH_SHARP);
               if ($urandom_range(2) == 0)
                  symbol_queue.push_back(CH_DOT);
               if ($urandom_range(1) == 0)
                  symbol_queue.push_back(8'(CH_FOUR + $urandom_range(3)));
               else if ($urandom_range(9) == 0)
                  symbol_queue.push_back(8'(CH_ZERO + $urandom_range(9)));
               if ($urandom_range(2) == 0)
                  symbol_queue.push_back(CH_DOT);
               k = $urandom_range(19);
               if (k < 17)
                  symbol_queue.push_back(CH_COMMA);
               else if (k < 19)
                  symbol_queue.push_back(CH_END);
               else
                  symbol_queue.push_back(8'($urandom_range(255)));
            end
         end
         wait_until_drained();

         // close any half-parsed note so the next setting starts clean
         while (!(step_now == AT_DURATION && digit_now == DIGIT_NONE)) begin
            symbol_queue.push_back(CH_END);
            wait_until_drained();
         end
         repeat (SETTLE_CYCLES) @(negedge clock);
      end

      if (fail_count == 0)
         $display("PASS ringtone_note_parser");
      else
         $display("FAIL ringtone_note_parser");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/rtp_pkg.sv
hdl/rtp_front.sv
hdl/rtp_queue.sv
hdl/rtp_back.sv
hdl/ringtone_note_parser.sv
tb/sv/tb_ringtone_note_parser.sv
